// File: rtl/fsk_pkg.sv
`timescale 1ns / 1ps
package fsk_pkg;

  // input kinds
  typedef enum logic [1:0] {
    KIND_BAUD    = 2'd0,
    KIND_MARK_MS = 2'd1,
    KIND_SILENCE = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  // register indexes
  localparam logic [2:0] REG_MARK_COS    = 3'd0;
  localparam logic [2:0] REG_MARK_SIN    = 3'd1;
  localparam logic [2:0] REG_SPACE_COS   = 3'd2;
  localparam logic [2:0] REG_SPACE_SIN   = 3'd3;
  localparam logic [2:0] REG_LAW_SELECT  = 3'd4;
  localparam logic [2:0] REG_BAUD_STEP   = 3'd5;
  localparam logic [2:0] REG_BAUD_PERIOD = 3'd6;

  localparam int COEF_W     = 18;
  localparam int COEF_FRAC  = 16;
  localparam int MAX_BAUD   = 17;
  localparam int ACC_W      = 15;

  // datapath operation for the current step
  typedef enum logic [2:0] {
    OP_ROT_R  = 3'd0,
    OP_ROT_I  = 3'd1,
    OP_MAG    = 3'd2,
    OP_NORM_R = 3'd3,
    OP_NORM_I = 3'd4,
    OP_SAMPLE = 3'd5
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load_sel;   // latch tone selection
    logic tone_mark;
    logic op_en;      // perform one op
    op_t  op;
    logic silence;    // compand zero
    logic acc_add;
    logic acc_clr;
  } fsk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic baud_done;  // accumulator plus step passes period on the current add
  } fsk_sts_t;

  // mu-law of a saturated linear sample
  function automatic logic [7:0] to_mulaw(input logic signed [15:0] s);
    logic [7:0]  sgn;
    logic [16:0] m;
    logic [2:0]  ex;
    logic [3:0]  mant;
    sgn = 8'h00;
    ex  = 3'd0;
    if (s < 0) begin
      sgn = 8'h80;
      m   = 17'(-{s[15], s});
    end else begin
      m   = 17'({1'b0, s});
    end
    if (m > 17'd32635) m = 17'd32635;
    m = m + 17'h84;
    for (int e = 1; e <= 7; e++) begin
      if ((m >> (e + 7)) != 0) ex = 3'(e);
    end
    mant = 4'((m >> (ex + 3)) & 17'hF);
    return ~(sgn | {1'b0, ex, mant});
  endfunction

  // A-law of a saturated linear sample
  function automatic logic [7:0] to_alaw(input logic signed [15:0] s);
    logic [7:0]  mask;
    logic [15:0] m;
    logic [2:0]  seg;
    logic [7:0]  aval;
    logic        found;
    seg   = 3'd7;
    found = 1'b0;
    if (s >= 0) begin
      mask = 8'hD5;
      m    = 16'(s) >> 3;
    end else begin
      mask = 8'h55;
      m    = 16'(~s) >> 3;
    end
    for (int k = 0; k < 7; k++) begin
      if (!found && m <= 16'((32'h20 << k) - 1)) begin
        seg   = 3'(k);
        found = 1'b1;
      end
    end
    aval = {1'b0, seg, 4'h0};
    if (seg < 3'd2) aval = aval | {4'h0, 4'((m >> 1) & 16'hF)};
    else            aval = aval | {4'h0, 4'((m >> seg) & 16'hF)};
    return aval ^ mask;
  endfunction

endpackage

// File: rtl/fsk_ctrl.sv
`timescale 1ns / 1ps
module fsk_ctrl
  import fsk_pkg::*;
#(
  parameter int SAMPLES_PER_MS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic       in_bit_value,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       out_last,
  output fsk_cmd_t   cmd,
  input  fsk_sts_t   sts
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC  = 6'b000010,
    ST_ACC   = 6'b000100,
    ST_OUT   = 6'b001000,
    ST_SIL   = 6'b010000,
    ST_SOUT  = 6'b100000
  } state_t;

  localparam int CNT_W = 5;

  state_t           state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             is_baud_r, is_baud_nxt;
  logic             last_r, last_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT) || (state_r == ST_SOUT);
  assign out_last  = last_r;

  // sequencer: six ops per sample, then accumulator for baud bits, then output
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    cnt_nxt     = cnt_r;
    is_baud_nxt = is_baud_r;
    last_nxt    = last_r;
    cmd         = '0;
    cmd.op      = op_r;
    cmd.tone_mark = (kind_t'(in_kind) == KIND_MARK_MS) || in_bit_value;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt = '0;
          op_nxt  = OP_ROT_R;
          priority case (kind_t'(in_kind))
            KIND_BAUD: begin
              cmd.load_sel = 1'b1;
              is_baud_nxt  = 1'b1;
              state_nxt    = ST_CALC;
            end
            KIND_MARK_MS: begin
              cmd.load_sel = 1'b1;
              is_baud_nxt  = 1'b0;
              state_nxt    = ST_CALC;
            end
            KIND_SILENCE: state_nxt = ST_SIL;
            default:      cmd.acc_clr = 1'b1;
          endcase
        end
      end
      ST_CALC: begin
        cmd.op_en = 1'b1;
        if (op_r == OP_SAMPLE) begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = is_baud_r ? ST_ACC : ST_OUT;
          last_nxt  = !is_baud_r && (cnt_r == CNT_W'(SAMPLES_PER_MS - 1));
        end else begin
          op_nxt = op_t'(op_r + 3'd1);
        end
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        last_nxt    = sts.baud_done || (cnt_r == CNT_W'(MAX_BAUD));
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          op_nxt    = OP_ROT_R;
          state_nxt = last_r ? ST_IDLE : ST_CALC;
        end
      end
      ST_SIL: begin
        cmd.silence = 1'b1;
        last_nxt    = 1'b1;
        state_nxt   = ST_SOUT;
      end
      ST_SOUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      op_r      <= OP_ROT_R;
      cnt_r     <= '0;
      is_baud_r <= 1'b0;
      last_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      op_r      <= op_nxt;
      cnt_r     <= cnt_nxt;
      is_baud_r <= is_baud_nxt;
      last_r    <= last_nxt;
    end
  end

  // no new item while a sample is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during output");
  // output held until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  // sample count bounded
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BAUD)) else $error("sample count overflow");

endmodule

// File: rtl/fsk_dp.sv
`timescale 1ns / 1ps
module fsk_dp
  import fsk_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fsk_cmd_t                 cmd,
  output fsk_sts_t                 sts,
  input  logic signed [COEF_W-1:0] mark_cos,
  input  logic signed [COEF_W-1:0] mark_sin,
  input  logic signed [COEF_W-1:0] space_cos,
  input  logic signed [COEF_W-1:0] space_sin,
  input  logic                     law_select,
  input  logic [11:0]              baud_step,
  input  logic [13:0]              baud_period,
  output logic [7:0]               code
);

  localparam int OSC_W  = FRAC_BITS + 4;
  // gain reaches 2^(FRAC_BITS+1) - 2^(OSC_W+3) LSBs when the phasor is saturated
  localparam int G_W    = OSC_W + 5;
  localparam int PROD_W = 2 * OSC_W + 5;
  localparam logic signed [PROD_W-1:0] OSC_MAX = PROD_W'((64'sd1 <<< (OSC_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] OSC_MIN = -PROD_W'(64'sd1 <<< (OSC_W - 1));

  logic signed [OSC_W-1:0]  re_r, im_r, nr_r, ni_r;
  logic signed [G_W-1:0]    g_r;
  logic signed [COEF_W-1:0] dc_r, ds_r;
  logic signed [PROD_W-1:0] pa, pb, sum;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] sat_v;
  logic [4:0]               shamt;
  logic signed [15:0]       lin;
  logic [7:0]               code_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W:0]           acc_sum;
  logic                     done_r;

  // round half away from zero by a variable shift
  function automatic logic signed [PROD_W-1:0] rshift(input logic signed [PROD_W-1:0] v,
                                                      input logic [4:0] n);
    logic [PROD_W-1:0] mag, half;
    half = PROD_W'(1) << (n - 1);
    if (v >= 0) return PROD_W'((PROD_W'(v) + half) >> n);
    mag = PROD_W'(-v);
    return -PROD_W'((mag + half) >> n);
  endfunction

  // one multiply or multiply pair per op
  always_comb begin
    pa    = '0;
    pb    = '0;
    shamt = 5'(FRAC_BITS);
    unique case (cmd.op)
      OP_ROT_R: begin
        pa = PROD_W'(re_r) * PROD_W'(dc_r);
        pb = -(PROD_W'(im_r) * PROD_W'(ds_r));
        shamt = 5'(COEF_FRAC);
      end
      OP_ROT_I: begin
        pa = PROD_W'(re_r) * PROD_W'(ds_r);
        pb = PROD_W'(im_r) * PROD_W'(dc_r);
        shamt = 5'(COEF_FRAC);
      end
      OP_MAG: begin
        pa = PROD_W'(nr_r) * PROD_W'(nr_r);
        pb = PROD_W'(ni_r) * PROD_W'(ni_r);
      end
      OP_NORM_R: pa = PROD_W'(nr_r) * PROD_W'(g_r);
      OP_NORM_I: pa = PROD_W'(ni_r) * PROD_W'(g_r);
      OP_SAMPLE: pa = PROD_W'(re_r) * PROD_W'(8192);
      default: ;
    endcase
    sum   = pa + pb;
    rnd   = rshift(sum, shamt);
    sat_v = (rnd > OSC_MAX) ? OSC_MAX : ((rnd < OSC_MIN) ? OSC_MIN : rnd);
    lin   = (rnd > 32767) ? 16'sd32767 : ((rnd < -32768) ? -16'sd32768 : 16'(rnd));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_r  <= OSC_W'(64'd1 << FRAC_BITS);
      im_r  <= '0;
      acc_r <= '0;
    end else begin
      if (cmd.load_sel) begin
        dc_r <= cmd.tone_mark ? mark_cos : space_cos;
        ds_r <= cmd.tone_mark ? mark_sin : space_sin;
      end
      if (cmd.op_en) begin
        unique case (cmd.op)
          OP_ROT_R:  nr_r <= OSC_W'(sat_v);
          OP_ROT_I:  ni_r <= OSC_W'(sat_v);
          OP_MAG:    g_r  <= G_W'((PROD_W'(2) <<< FRAC_BITS) - rnd);
          OP_NORM_R: re_r <= OSC_W'(sat_v);
          OP_NORM_I: im_r <= OSC_W'(sat_v);
          OP_SAMPLE: code_r <= law_select ? to_alaw(lin) : to_mulaw(lin);
          default: ;
        endcase
      end
      if (cmd.silence) code_r <= law_select ? 8'hD5 : 8'hFF;
      // baud accumulator keeps the remainder
      if (cmd.acc_clr) acc_r <= '0;
      else if (cmd.acc_add) begin
        if (acc_sum > (ACC_W+1)'(baud_period)) acc_r <= ACC_W'(acc_sum - baud_period);
        else                                   acc_r <= ACC_W'(acc_sum);
      end
      if (cmd.acc_add) done_r <= acc_sum > (ACC_W+1)'(baud_period);
    end
  end

  assign acc_sum        = (ACC_W+1)'(acc_r) + (ACC_W+1)'(baud_step);
  assign sts.baud_done  = acc_sum > (ACC_W+1)'(baud_period);
  assign code           = code_r;

  // silence gives one of the two zero codes
  a_sil_code: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.silence |=> (code_r == 8'hD5 || code_r == 8'hFF)) else $error("bad silence code");
  a_acc_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_add && sts.baud_done |=> done_r) else $error("baud flag lost");
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_clr |=> acc_r == '0) else $error("accumulator not cleared");

endmodule

// File: rtl/fsk_callerid_modulator.sv
`timescale 1ns / 1ps
// Continuous-phase FSK caller ID modulator with G.711 output. Each sample of a baud bit
// runs six multiply steps through one shared multiplier pair, an accumulator step and
// the output transfer; a one-millisecond mark sample skips the accumulator step. A baud
// bit gives up to 17 samples and a mark millisecond SAMPLES_PER_MS (eight by default);
// each output transfer can stall on out_ready. A silence item gives one zero-code sample
// and a restart clears the baud accumulator. One item is handled at a time; registers
// are written over the cfg_ APB port at byte address 4*index and should only be changed
// while the block is idle.
module fsk_callerid_modulator
  import fsk_pkg::*;
#(
  parameter int SAMPLES_PER_MS = 8,
  parameter int FRAC_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic        in_bit_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_code,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic signed [COEF_W-1:0] mark_cos_r, mark_sin_r, space_cos_r, space_sin_r;
  logic                     law_r;
  logic [11:0]              step_r;
  logic [13:0]              period_r;
  logic [2:0]               idx;
  fsk_cmd_t                 cmd;
  fsk_sts_t                 sts;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_cos_r  <= 18'sd38521;
      mark_sin_r  <= 18'sd53020;
      space_cos_r <= -18'sd10252;
      space_sin_r <= 18'sd64729;
      law_r       <= 1'b0;
      step_r      <= 12'd1200;
      period_r    <= 14'd8000;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (idx)
        REG_MARK_COS:    mark_cos_r  <= cfg_pwdata[COEF_W-1:0];
        REG_MARK_SIN:    mark_sin_r  <= cfg_pwdata[COEF_W-1:0];
        REG_SPACE_COS:   space_cos_r <= cfg_pwdata[COEF_W-1:0];
        REG_SPACE_SIN:   space_sin_r <= cfg_pwdata[COEF_W-1:0];
        REG_LAW_SELECT:  law_r       <= cfg_pwdata[0];
        REG_BAUD_STEP:   step_r      <= cfg_pwdata[11:0];
        REG_BAUD_PERIOD: period_r    <= cfg_pwdata[13:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (idx)
      REG_MARK_COS:    cfg_prdata = 32'(mark_cos_r);
      REG_MARK_SIN:    cfg_prdata = 32'(mark_sin_r);
      REG_SPACE_COS:   cfg_prdata = 32'(space_cos_r);
      REG_SPACE_SIN:   cfg_prdata = 32'(space_sin_r);
      REG_LAW_SELECT:  cfg_prdata = {31'd0, law_r};
      REG_BAUD_STEP:   cfg_prdata = {20'd0, step_r};
      REG_BAUD_PERIOD: cfg_prdata = {18'd0, period_r};
      default:         cfg_prdata = '0;
    endcase
  end

  fsk_ctrl #(.SAMPLES_PER_MS(SAMPLES_PER_MS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind, .in_bit_value,
    .out_ready, .out_valid, .out_last, .cmd, .sts
  );

  fsk_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .mark_cos(mark_cos_r), .mark_sin(mark_sin_r),
    .space_cos(space_cos_r), .space_sin(space_sin_r),
    .law_select(law_r), .baud_step(step_r), .baud_period(period_r),
    .code(out_code)
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import fsk_pkg::*;

  localparam int FRAC = 16;
  localparam int SPMS = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    kind_t kind;
    logic  bit_value;
  } tone_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } sample_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic        in_bit_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_code;
  logic        out_last;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  fsk_callerid_modulator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_bit_value(in_bit_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_code(out_code),
    .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // predictor state and register copy
  logic signed [17:0] p_mark_cos, p_mark_sin, p_space_cos, p_space_sin;
  logic               p_alaw;
  logic [11:0]        p_baud_step;
  logic [13:0]        p_baud_period;
  longint             osc_re, osc_im;
  logic [14:0]        baud_acc;

  tone_item_t pending_items[$];
  sample_t    expected_samples[$];
  int         fail_count;
  int         idle_cycles;
  bit         stim_done;

  function automatic longint round_shift(longint v, int n);
    longint half;
    half = longint'(1) << (n - 1);
    if (v >= 0) return (v + half) >>> n;
    return -((-v + half) >>> n);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clamp_osc(longint v);
    longint lim;
    lim = longint'(1) << (FRAC + 3);
    return clamp(v, -lim, lim - 1);
  endfunction

  function automatic logic [7:0] mulaw_code(longint s);
    longint mag;
    int     ex;
    logic [7:0] sgn;
    sgn = (s < 0) ? 8'h80 : 8'h00;
    mag = (s < 0) ? -s : s;
    if (mag > 32635) mag = 32635;
    mag = mag + 132;
    ex = 0;
    for (int e = 7; e >= 1; e--) begin
      if ((mag >> (e + 7)) != 0 && ex == 0) ex = e;
    end
    return ~(sgn | 8'(ex << 4) | 8'((mag >> (ex + 3)) & 15));
  endfunction

  function automatic logic [7:0] alaw_code(longint s);
    longint m;
    int     seg;
    logic [7:0] mask, aval;
    if (s >= 0) begin
      mask = 8'hD5;
      m = s >> 3;
    end else begin
      mask = 8'h55;
      m = (-(s + 1)) >> 3;
    end
    seg = 7;
    for (int k = 6; k >= 0; k--)
      if (m <= (longint'(32) << k) - 1) seg = k;
    aval = 8'(seg << 4);
    if (seg < 2) aval = aval | 8'((m >> 1) & 15);
    else         aval = aval | 8'((m >> seg) & 15);
    return aval ^ mask;
  endfunction

  function automatic logic [7:0] companded(longint s);
    return p_alaw ? alaw_code(s) : mulaw_code(s);
  endfunction

  // one oscillator rotation with renormalisation, returns the sample code
  function automatic logic [7:0] next_tone_code(bit mark);
    longint dr, di, nr, ni, mag, gain, lin;
    dr = mark ? longint'(p_mark_cos) : longint'(p_space_cos);
    di = mark ? longint'(p_mark_sin) : longint'(p_space_sin);
    nr = clamp_osc(round_shift(osc_re * dr - osc_im * di, 16));
    ni = clamp_osc(round_shift(osc_re * di + osc_im * dr, 16));
    mag = round_shift(nr * nr + ni * ni, FRAC);
    gain = (longint'(2) << FRAC) - mag;
    osc_re = clamp_osc(round_shift(nr * gain, FRAC));
    osc_im = clamp_osc(round_shift(ni * gain, FRAC));
    lin = clamp(round_shift(osc_re * 8192, FRAC), -32768, 32767);
    return companded(lin);
  endfunction

  task automatic predict_samples(tone_item_t it);
    sample_t s;
    int      n;
    logic [15:0] acc;
    n = 0;
    case (it.kind)
      KIND_BAUD: begin
        while (n < MAX_BAUD) begin
          s.code = next_tone_code(it.bit_value);
          s.last = 1'b0;
          expected_samples.push_back(s);
          n++;
          acc = {1'b0, baud_acc} + p_baud_step;
          if (acc > p_baud_period) begin
            baud_acc = 15'(acc - p_baud_period);
            break;
          end
          baud_acc = acc[14:0];
        end
      end
      KIND_MARK_MS: begin
        for (int i = 0; i < SPMS; i++) begin
          s.code = next_tone_code(1'b1);
          s.last = 1'b0;
          expected_samples.push_back(s);
          n++;
        end
      end
      KIND_SILENCE: begin
        s.code = companded(0);
        s.last = 1'b0;
        expected_samples.push_back(s);
        n = 1;
      end
      default: baud_acc = '0;
    endcase
    if (n > 0) expected_samples[$].last = 1'b1;
  endtask

  // register write over apb, also updates the predictor copy
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MARK_COS:    p_mark_cos = value[17:0];
      REG_MARK_SIN:    p_mark_sin = value[17:0];
      REG_SPACE_COS:   p_space_cos = value[17:0];
      REG_SPACE_SIN:   p_space_sin = value[17:0];
      REG_LAW_SELECT:  p_alaw = value[0];
      REG_BAUD_STEP:   p_baud_step = value[11:0];
      REG_BAUD_PERIOD: p_baud_period = value[13:0];
      default: ;
    endcase
  endtask

  task automatic add_item(logic [1:0] kind, logic bit_value);
    tone_item_t it;
    it.kind = kind_t'(kind);
    it.bit_value = bit_value;
    pending_items.push_back(it);
  endtask

  // wait for the block to drain before a register change
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)      add_item(KIND_BAUD, 1'($urandom));
      else if (r < 75) add_item(KIND_MARK_MS, 1'($urandom));
      else if (r < 90) add_item(KIND_SILENCE, 1'($urandom));
      else             add_item(KIND_RESTART, 1'($urandom));
    end
    wait_idle();
  endtask

  // driver: one transfer per item with random gaps
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_kind      <= '0;
      in_bit_value <= 1'b0;
      in_gap       <= 0;
    end else if (in_valid && !in_ready) begin
    end else if (in_gap > 0) begin
      if (in_valid) begin
        in_valid <= 1'b0;
        predict_samples(pending_items.pop_front());
      end
      in_gap <= in_gap - 1;
    end else begin
      if (in_valid) predict_samples(pending_items.pop_front());
      if (pending_items.size() > 0) begin
        in_valid     <= 1'b1;
        in_kind      <= pending_items[0].kind;
        in_bit_value <= pending_items[0].bit_value;
        in_gap       <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: random stall on out_ready, compare each transfer
  int out_stall;
  always @(posedge clk) begin
    sample_t exp_s;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample code=%02h last=%0b", $time, out_code, out_last);
          fail_count++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (out_code !== exp_s.code) begin
            $display("%0t: code expected %02h actual %02h", $time, exp_s.code, out_code);
            fail_count++;
          end
          if (out_last !== exp_s.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_s.last, out_last);
            fail_count++;
          end
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall <= out_stall - 1;
      end else if (out_valid && out_ready || !out_ready) begin
        out_ready <= 1'b1;
        out_stall <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !stim_done) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    fail_count   = 0;
    stim_done    = 1'b0;
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    p_mark_cos    = 18'sd38521;
    p_mark_sin    = 18'sd53020;
    p_space_cos   = -18'sd10252;
    p_space_sin   = 18'sd64729;
    p_alaw        = 1'b0;
    p_baud_step   = 12'd1200;
    p_baud_period = 14'd8000;
    osc_re   = longint'(1) << FRAC;
    osc_im   = 0;
    baud_acc = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every kind, both bit values, restart mid-stream
    add_item(KIND_BAUD, 1'b1);
    add_item(KIND_BAUD, 1'b0);
    add_item(KIND_MARK_MS, 1'b0);
    add_item(KIND_MARK_MS, 1'b1);
    add_item(KIND_SILENCE, 1'b0);
    add_item(KIND_SILENCE, 1'b1);
    add_item(KIND_BAUD, 1'b0);
    add_item(KIND_RESTART, 1'b1);
    add_item(KIND_BAUD, 1'b1);
    add_item(KIND_RESTART, 1'b0);
    add_item(KIND_SILENCE, 1'b0);
    wait_idle();

    // a-law, slow baud: up to 17 samples per bit, extremes of the steps
    write_reg(REG_LAW_SELECT, 32'd1);
    write_reg(REG_BAUD_STEP, 32'd1);
    write_reg(REG_BAUD_PERIOD, 32'd16383);
    write_reg(REG_MARK_COS, 32'(18'sh10000));
    write_reg(REG_MARK_SIN, 32'(-18'sd65536));
    add_item(KIND_BAUD, 1'b1);
    add_item(KIND_SILENCE, 1'b0);
    add_item(KIND_MARK_MS, 1'b0);
    add_item(KIND_BAUD, 1'b0);
    wait_idle();

    // fastest baud with odd steps, over-range phasor growth
    write_reg(REG_BAUD_STEP, 32'd4095);
    write_reg(REG_BAUD_PERIOD, 32'd0);
    write_reg(REG_SPACE_COS, 32'(-18'sd131072));
    write_reg(REG_SPACE_SIN, 32'(18'sd131071));
    add_item(KIND_BAUD, 1'b0);
    add_item(KIND_BAUD, 1'b0);
    add_item(KIND_BAUD, 1'b1);
    add_item(KIND_RESTART, 1'b0);
    wait_idle();

    // random phases across several settings
    write_reg(REG_LAW_SELECT, 32'd0);
    write_reg(REG_BAUD_STEP, 32'd1200);
    write_reg(REG_BAUD_PERIOD, 32'd8000);
    write_reg(REG_MARK_COS, 32'd38521);
    write_reg(REG_MARK_SIN, 32'd53020);
    write_reg(REG_SPACE_COS, 32'(-18'sd10252));
    write_reg(REG_SPACE_SIN, 32'd64729);
    random_phase(55);

    write_reg(REG_LAW_SELECT, 32'd1);
    write_reg(REG_BAUD_STEP, 32'($urandom_range(1000, 4000)));
    write_reg(REG_BAUD_PERIOD, 32'($urandom_range(8000, 16000)));
    random_phase(45);

    for (int r = 0; r < 4; r++)
      write_reg(3'(r), 32'($urandom_range(0, 131071)) - 32'd65536);
    write_reg(REG_LAW_SELECT, 32'($urandom_range(0, 1)));
    write_reg(REG_BAUD_STEP, 32'($urandom_range(0, 4095)));
    write_reg(REG_BAUD_PERIOD, 32'($urandom_range(0, 16383)));
    random_phase(55);

    stim_done = 1'b1;
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
